[sv/kplc_pkg.sv]
// Package: shared types, codes and sizing constants for the keypad PIN lock controller.
package kplc_pkg;

  localparam int PIN_DIGITS = 4;
  localparam int TIMER_BITS = 32;
  localparam int DUR_BITS   = 32;
  localparam int PIN_BITS   = 4 * PIN_DIGITS;
  localparam int LEN_W      = $clog2(PIN_DIGITS + 1);
  localparam int IDX_W      = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
  localparam int CMP_W      = (TIMER_BITS > DUR_BITS) ? TIMER_BITS : DUR_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] PIN_RESET   = 16'd0;
  localparam logic [3:0]  MAX_RESET   = 4'd3;
  localparam logic [31:0] GRANT_RESET = 32'd5000;
  localparam logic [31:0] LOCK_RESET  = 32'd30000;
  localparam logic [3:0]  FAIL_MAX    = 4'd15;
  localparam logic [3:0]  DIGIT_MAX   = 4'd9;

  typedef enum logic [1:0] {
    MODE_ENTRY   = 2'd0,
    MODE_GRANTED = 2'd1,
    MODE_LOCKED  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_DIGIT  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SUBMIT = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    SND_NONE    = 3'd0,
    SND_CLICK   = 3'd1,
    SND_SUCCESS = 3'd2,
    SND_FAIL    = 3'd3,
    SND_LOCKOUT = 3'd4
  } sound_t;

  typedef enum logic [1:0] {
    MSG_NONE   = 2'd0,
    MSG_ENTER  = 2'd1,
    MSG_SHORT  = 2'd2,
    MSG_DENIED = 2'd3
  } msg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIN_CODE  = 2'd0,
    REG_MAX_ATT   = 2'd1,
    REG_GRANT_DUR = 2'd2,
    REG_LOCK_DUR  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PIN_BITS-1:0] pin_code;
    logic [3:0]          max_attempts;
    logic [DUR_BITS-1:0] grant_dur;
    logic [DUR_BITS-1:0] lock_dur;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic             door_open;
    sound_t           sound;
    msg_t             message;
    logic [LEN_W-1:0] entered_count;
    logic [3:0]       attempts_left;
  } res_t;

endpackage

[sv/kplc_cfg.sv]
// Configuration register file: PIN, attempt limit and both period lengths.
module kplc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [kplc_pkg::CFG_IDX_W-1:0] wr_idx,
  input  logic [kplc_pkg::CFG_DATA_W-1:0] wr_data,
  output kplc_pkg::cfg_t                 cfg
);
  import kplc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pin_code     <= PIN_RESET[PIN_BITS-1:0];
      cfg_r.max_attempts <= MAX_RESET;
      cfg_r.grant_dur    <= GRANT_RESET;
      cfg_r.lock_dur     <= LOCK_RESET;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_idx))
        REG_PIN_CODE:  cfg_r.pin_code     <= wr_data[PIN_BITS-1:0];
        REG_MAX_ATT:   cfg_r.max_attempts <= wr_data[3:0];
        REG_GRANT_DUR: cfg_r.grant_dur    <= wr_data[DUR_BITS-1:0];
        REG_LOCK_DUR:  cfg_r.lock_dur     <= wr_data[DUR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/kplc_core.sv]
// Lock state machine: mode, entered digits, failure count and period timer.
module kplc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  kplc_pkg::cmd_t      command,
  input  logic [3:0]          digit,
  input  kplc_pkg::cfg_t      cfg,
  output kplc_pkg::res_t      res
);
  import kplc_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [3:0]            fail_r, fail_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [3:0]            digits_r [PIN_DIGITS];
  logic                  dig_we;
  logic                  pin_ok;
  logic [CMP_W-1:0]      elapsed_ext, dur_ext;
  sound_t                sound;
  msg_t                  message;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ENTRY;
      len_r     <= '0;
      fail_r    <= '0;
      elapsed_r <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      len_r     <= len_nxt;
      fail_r    <= fail_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && dig_we) begin
      digits_r[len_r[IDX_W-1:0]] <= digit;
    end
  end

  always_comb begin
    pin_ok = 1'b1;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      if (cfg.pin_code[4*(PIN_DIGITS-1-i) +: 4] != digits_r[i]) begin
        pin_ok = 1'b0;
      end
    end
  end

  assign elapsed_ext = CMP_W'(elapsed_r);
  assign dur_ext     = (mode_r == MODE_GRANTED) ? CMP_W'(cfg.grant_dur) : CMP_W'(cfg.lock_dur);

  always_comb begin
    mode_nxt    = mode_r;
    len_nxt     = len_r;
    fail_nxt    = fail_r;
    elapsed_nxt = elapsed_r;
    dig_we      = 1'b0;
    sound       = SND_NONE;
    message     = MSG_NONE;
    if (command == CMD_TICK) begin
      if (mode_r != MODE_ENTRY) begin
        if (elapsed_ext >= dur_ext) begin
          if (mode_r == MODE_LOCKED) begin
            fail_nxt = '0;
          end
          mode_nxt = MODE_ENTRY;
          len_nxt  = '0;
          message  = MSG_ENTER;
        end else if (elapsed_r != '1) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
      end
    end else if (mode_r == MODE_ENTRY) begin
      case (command)
        CMD_DIGIT: begin
          if (len_r < LEN_W'(PIN_DIGITS) && digit <= DIGIT_MAX) begin
            dig_we  = 1'b1;
            len_nxt = len_r + 1'b1;
            sound   = SND_CLICK;
          end
        end
        CMD_CLEAR: begin
          len_nxt = '0;
          sound   = SND_CLICK;
          message = MSG_ENTER;
        end
        CMD_SUBMIT: begin
          if (len_r != LEN_W'(PIN_DIGITS)) begin
            sound   = SND_FAIL;
            message = MSG_SHORT;
          end else if (pin_ok) begin
            fail_nxt    = '0;
            mode_nxt    = MODE_GRANTED;
            elapsed_nxt = '0;
            sound       = SND_SUCCESS;
          end else begin
            if (fail_r != FAIL_MAX) begin
              fail_nxt = fail_r + 1'b1;
            end
            if (fail_nxt >= cfg.max_attempts) begin
              mode_nxt    = MODE_LOCKED;
              elapsed_nxt = '0;
              sound       = SND_LOCKOUT;
            end else begin
              sound   = SND_FAIL;
              message = MSG_DENIED;
              len_nxt = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.mode          = mode_nxt;
    res.door_open     = (mode_nxt == MODE_GRANTED);
    res.sound         = sound;
    res.message       = message;
    res.entered_count = len_nxt;
    res.attempts_left = (fail_nxt >= cfg.max_attempts) ? 4'd0 : cfg.max_attempts - fail_nxt;
  end

endmodule

[sv/keypad_pin_lock_controller_top.sv]
// Top level: input register, lock core, result register and configuration port.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-----------------------------
//  input   | in_command, in_digit                   | in_valid / in_stall
//  result  | out_mode, out_door_open, out_sound,    | out_valid / out_stall
//          | out_message, out_entered_count,        |
//          | out_attempts_left                      |
//  config  | cfg_index, cfg_data                    | cfg_valid / cfg_ready
//
// One item per cycle sustained while the result side does not stall; an item's
// result is registered (input register, then state update into the result register).
// The state update runs in the same cycle the item leaves the input register.
// A stall on the result side holds the result register, then the input register.
// Synchronous active-low reset returns to entry mode with reset register values.
module keypad_pin_lock_controller_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [3:0]                      in_digit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_mode,
  output logic                            out_door_open,
  output logic [2:0]                      out_sound,
  output logic [1:0]                      out_message,
  output logic [kplc_pkg::LEN_W-1:0]      out_entered_count,
  output logic [3:0]                      out_attempts_left,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kplc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kplc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kplc_pkg::*;

  logic       iv_r;
  cmd_t       cmd_r;
  logic [3:0] dig_r;
  logic       ov_r;
  res_t       res_r;
  res_t       res;
  cfg_t       cfg;
  logic       out_free, step, in_take;

  assign out_free = !ov_r || !out_stall;
  assign step     = iv_r && out_free;
  assign in_stall = iv_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  kplc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  kplc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .command (cmd_r),
    .digit   (dig_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (in_take) begin
        iv_r <= 1'b1;
      end else if (step) begin
        iv_r <= 1'b0;
      end
      if (step) begin
        ov_r <= 1'b1;
      end else if (out_free) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= cmd_t'(in_command);
      dig_r <= in_digit;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid         = ov_r;
  assign out_mode          = res_r.mode;
  assign out_door_open     = res_r.door_open;
  assign out_sound         = res_r.sound;
  assign out_message       = res_r.message;
  assign out_entered_count = res_r.entered_count;
  assign out_attempts_left = res_r.attempts_left;

endmodule

[bench/kplc_lock_scoreboard.sv]
// Scoreboard class: predicts the lock controller result for each accepted key event.
package kplc_bench_pkg;
  import kplc_pkg::*;

  class lock_scoreboard;
    cfg_t                  regs;
    mode_t                 mode;
    logic [3:0]            digits [PIN_DIGITS];
    int unsigned           len;
    logic [3:0]            fails;
    logic [TIMER_BITS-1:0] elapsed;
    res_t                  expected_panel_q [$];
    int unsigned           errors;

    function new();
      regs.pin_code     = PIN_RESET;
      regs.max_attempts = MAX_RESET;
      regs.grant_dur    = GRANT_RESET;
      regs.lock_dur     = LOCK_RESET;
      mode    = MODE_ENTRY;
      len     = 0;
      fails   = '0;
      elapsed = '0;
      errors  = 0;
      foreach (digits[i]) digits[i] = '0;
    endfunction

    function int unsigned pending();
      return expected_panel_q.size();
    endfunction

    task report_mismatch(string what);
      if (errors < 100) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function void write_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PIN_CODE:  regs.pin_code     = data[PIN_BITS-1:0];
        REG_MAX_ATT:   regs.max_attempts = data[3:0];
        REG_GRANT_DUR: regs.grant_dur    = data[DUR_BITS-1:0];
        REG_LOCK_DUR:  regs.lock_dur     = data[DUR_BITS-1:0];
        default: ;
      endcase
    endfunction

    function bit entry_matches();
      for (int i = 0; i < PIN_DIGITS; i++)
        if (regs.pin_code[4*(PIN_DIGITS-1-i) +: 4] != digits[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void predict_key_event(cmd_t cmd, logic [3:0] digit);
      res_t                want;
      sound_t              snd;
      msg_t                msg;
      logic [DUR_BITS-1:0] span;
      snd = SND_NONE;
      msg = MSG_NONE;
      if (cmd == CMD_TICK) begin
        if (mode != MODE_ENTRY) begin
          span = (mode == MODE_GRANTED) ? regs.grant_dur : regs.lock_dur;
          if (elapsed >= span) begin
            if (mode == MODE_LOCKED) fails = '0;
            mode = MODE_ENTRY;
            len  = 0;
            msg  = MSG_ENTER;
          end else if (elapsed != '1) begin
            elapsed++;
          end
        end
      end else if (mode == MODE_ENTRY) begin
        case (cmd)
          CMD_DIGIT: begin
            if (len < PIN_DIGITS && digit <= DIGIT_MAX) begin
              digits[len] = digit;
              len++;
              snd = SND_CLICK;
            end
          end
          CMD_CLEAR: begin
            len = 0;
            snd = SND_CLICK;
            msg = MSG_ENTER;
          end
          default: begin
            if (len != PIN_DIGITS) begin
              snd = SND_FAIL;
              msg = MSG_SHORT;
            end else if (entry_matches()) begin
              fails   = '0;
              mode    = MODE_GRANTED;
              elapsed = '0;
              snd     = SND_SUCCESS;
            end else begin
              if (fails != FAIL_MAX) fails++;
              if (fails >= regs.max_attempts) begin
                mode    = MODE_LOCKED;
                elapsed = '0;
                snd     = SND_LOCKOUT;
              end else begin
                snd = SND_FAIL;
                msg = MSG_DENIED;
                len = 0;
              end
            end
          end
        endcase
      end
      want.mode          = mode;
      want.door_open     = (mode == MODE_GRANTED);
      want.sound         = snd;
      want.message       = msg;
      want.entered_count = LEN_W'(len);
      want.attempts_left = (fails >= regs.max_attempts) ? 4'd0 : regs.max_attempts - fails;
      expected_panel_q.push_back(want);
    endfunction

    task compare_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_panel_result(res_t got);
      res_t want;
      if (expected_panel_q.size() == 0) begin
        report_mismatch("result with no pending item");
        return;
      end
      want = expected_panel_q.pop_front();
      compare_field("mode", 4'(got.mode), 4'(want.mode));
      compare_field("door_open", 4'(got.door_open), 4'(want.door_open));
      compare_field("sound", 4'(got.sound), 4'(want.sound));
      compare_field("message", 4'(got.message), 4'(want.message));
      compare_field("entered_count", 4'(got.entered_count), 4'(want.entered_count));
      compare_field("attempts_left", got.attempts_left, want.attempts_left);
    endtask
  endclass

endpackage

[bench/tb_keypad_pin_lock_controller_top.sv]
// Testbench top: drives key events and register writes, checks every lock result.
module tb_keypad_pin_lock_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kplc_pkg::*;
  import kplc_bench_pkg::*;

  localparam int HOLD_CYCLES = 60;

  typedef struct {
    cmd_t       cmd;
    logic [3:0] digit;
  } key_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_command;
  logic [3:0]            in_digit;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_mode;
  logic                  out_door_open;
  logic [2:0]            out_sound;
  logic [1:0]            out_message;
  logic [LEN_W-1:0]      out_entered_count;
  logic [3:0]            out_attempts_left;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit          hold_start = 1'b0;
  int unsigned burst_left = 0;
  key_item_t   key_events_q [$];
  lock_scoreboard sb = new();

  keypad_pin_lock_controller_top dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.predict_key_event(cmd_t'(in_command), in_digit);
    if (rst_n && cfg_valid && cfg_ready)
      sb.write_register(reg_idx_t'(cfg_index), cfg_data);
    if (rst_n && out_valid && !out_stall)
      sb.check_panel_result(res_t'({out_mode, out_door_open, out_sound, out_message,
                                     out_entered_count, out_attempts_left}));
  end

  initial begin : result_sink
    int unsigned style, win, k;
    out_stall = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      win   = $urandom_range(16, 96);
      for (k = 0; k < win; k++) begin
        @(negedge clk);
        if (hold_start) begin
          hold_start = 1'b0;
          out_stall  = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (style)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 3) == 0);
          2:       out_stall = ($urandom_range(0, 9) < 7);
          default: out_stall = k[1];
        endcase
      end
    end
  end

  task automatic queue_key(cmd_t cmd, logic [3:0] digit);
    key_item_t it;
    it.cmd   = cmd;
    it.digit = digit;
    key_events_q.push_back(it);
  endtask

  task automatic queue_pin(logic [PIN_BITS-1:0] pin);
    for (int i = 0; i < PIN_DIGITS; i++)
      queue_key(CMD_DIGIT, pin[4*(PIN_DIGITS-1-i) +: 4]);
  endtask

  task automatic queue_ticks(int unsigned n);
    repeat (n) queue_key(CMD_TICK, 4'($urandom_range(0, 15)));
  endtask

  task automatic queue_random(int unsigned count, logic [PIN_BITS-1:0] pin, int unsigned span);
    int unsigned pick, target;
    logic [PIN_BITS-1:0] other;
    target = key_events_q.size() + count;
    while (key_events_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        other = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        queue_pin($urandom_range(0, 1) ? pin : other);
        if ($urandom_range(0, 9) == 0)
          queue_key(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        queue_key(CMD_SUBMIT, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 2) != 0) queue_ticks(span + 1 + $urandom_range(0, 2));
      end else if (pick < 68) begin
        queue_ticks($urandom_range(1, span + 2));
      end else if (pick < 78) begin
        repeat ($urandom_range(0, 3)) queue_key(CMD_DIGIT, 4'($urandom_range(0, 9)));
        queue_key(CMD_SUBMIT, 4'($urandom_range(0, 15)));
      end else if (pick < 84) begin
        queue_key(CMD_CLEAR, 4'($urandom_range(0, 15)));
      end else begin
        queue_key(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  task automatic run_stimulus();
    key_item_t   it;
    int unsigned gap;
    while (key_events_q.size() != 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      it = key_events_q.pop_front();
      in_valid   = 1'b1;
      in_command = it.cmd;
      in_digit   = it.digit;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
      burst_left--;
    end
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_lock(logic [15:0] pin, logic [3:0] max_att,
                              logic [31:0] grant, logic [31:0] lock);
    write_reg(REG_PIN_CODE, {16'($urandom()), pin});
    write_reg(REG_MAX_ATT, {28'($urandom()), max_att});
    write_reg(REG_GRANT_DUR, grant);
    write_reg(REG_LOCK_DUR, lock);
  endtask

  initial begin : limit
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    int unsigned  ph;
    logic [15:0]  pin;
    logic [3:0]   max_att;
    logic [31:0]  g_dur, l_dur;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_DIGIT;
    in_digit   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_PIN_CODE;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: tick in entry, bad digit, short submit, clear, full entry, grant
    queue_ticks(1);
    queue_key(CMD_DIGIT, 4'd10);
    queue_key(CMD_SUBMIT, 4'd15);
    queue_key(CMD_DIGIT, 4'd9);
    queue_key(CMD_CLEAR, 4'd0);
    queue_pin(16'h0000);
    queue_key(CMD_DIGIT, 4'd5);
    queue_key(CMD_SUBMIT, 4'd0);
    queue_key(CMD_DIGIT, 4'd3);
    queue_key(CMD_CLEAR, 4'd0);
    queue_key(CMD_SUBMIT, 4'd0);
    queue_ticks(1);
    run_stimulus();
    wait_drained();
    write_reg(REG_GRANT_DUR, 32'd0);
    queue_ticks(1);
    run_stimulus();
    wait_drained();

    // zero attempts locks on first miss; endless periods cut short by a rewrite
    program_lock(16'h9999, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_pin(16'h1234);
    queue_key(CMD_SUBMIT, 4'd0);
    queue_ticks(2);
    run_stimulus();
    wait_drained();
    write_reg(REG_LOCK_DUR, 32'd0);
    queue_ticks(1);
    queue_pin(16'h9999);
    queue_key(CMD_SUBMIT, 4'd0);
    queue_ticks(2);
    run_stimulus();
    wait_drained();
    write_reg(REG_GRANT_DUR, 32'd1);
    queue_ticks(1);
    run_stimulus();
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      pin = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
             4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      case (ph)
        0: begin max_att = 4'd1;  g_dur = 32'd0; l_dur = 32'd0; end
        1: begin max_att = 4'd15; g_dur = 32'd3; l_dur = 32'd2; end
        2: begin pin = 16'hFFFF; max_att = 4'd2; g_dur = 32'd1; l_dur = 32'd5; end
        3: begin pin = 16'($urandom()); max_att = 4'd0; g_dur = 32'd4; l_dur = 32'd1; end
        default: begin
          max_att = 4'($urandom_range(1, 15));
          g_dur   = $urandom_range(0, 6);
          l_dur   = $urandom_range(0, 6);
        end
      endcase
      program_lock(pin, max_att, g_dur, l_dur);
      if (ph == 2) hold_start = 1'b1;
      if (ph == 1) begin
        queue_random(50, pin, (g_dur > l_dur) ? g_dur : l_dur);
        run_stimulus();
        wait_drained();
        queue_random(50, pin, (g_dur > l_dur) ? g_dur : l_dur);
      end else begin
        queue_random(100, pin, (g_dur > l_dur) ? g_dur : l_dur);
      end
      run_stimulus();
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
sv/kplc_pkg.sv
sv/kplc_cfg.sv
sv/kplc_core.sv
sv/keypad_pin_lock_controller_top.sv
bench/kplc_lock_scoreboard.sv
bench/tb_keypad_pin_lock_controller_top.sv
